// ----- rtl/assert_macros.svh -----
// assertion macros shared by the scheduler rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the following cycle
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// condition never holds
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);

`else

`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)

`endif

`endif

// ----- rtl/pbts_pkg.sv -----
// types and constants of the priority bitmap scheduler
`default_nettype none

package pbts_pkg;

   // field widths
   localparam int ACT_W   = 2;
   localparam int PRIO_W  = 6;
   localparam int TASK_W  = 5;
   localparam int TSTAT_W = 2;
   localparam int CTX_W   = 2;
   localparam int STAT_W  = 2;

   // default number of priority levels
   localparam int PRIO_LEVELS_DEF = 32;

   // task id that stands for the idle task
   localparam logic [TASK_W-1:0] IDLE_TASK_ID = TASK_W'(16);

   // action codes
   localparam logic [ACT_W-1:0] ACT_SET   = 2'd0;
   localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd1;
   localparam logic [ACT_W-1:0] ACT_SCHED = 2'd2;

   // call context codes
   localparam logic [CTX_W-1:0] CTX_TASK = 2'd0;
   localparam logic [CTX_W-1:0] CTX_CAT2 = 2'd2;

   // current task state codes
   localparam logic [TSTAT_W-1:0] TS_RUNNING   = 2'd0;
   localparam logic [TSTAT_W-1:0] TS_WAITING   = 2'd2;
   localparam logic [TSTAT_W-1:0] TS_SUSPENDED = 2'd3;

   // result status codes
   localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
   localparam logic [STAT_W-1:0] ST_RES_ERR  = 2'd1;
   localparam logic [STAT_W-1:0] ST_CALL_ERR = 2'd2;

   // one request item
   typedef struct packed {
      logic [ACT_W-1:0]   action;
      logic [PRIO_W-1:0]  prio;
      logic [TASK_W-1:0]  task_id;
      logic [TSTAT_W-1:0] task_status;
      logic               preemptable;
      logic               resource_held;
      logic [CTX_W-1:0]   call_context;
      logic               isr_level;
      logic               dispatch_locked;
      logic               os_running;
   } req_item_type;

   // one response item
   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [TASK_W-1:0] high_task;
      logic              dispatch_now;
      logic              defer_dispatch;
      logic              preempted;
      logic              post_hook;
   } rsp_item_type;

endpackage

`default_nettype wire

// ----- rtl/pbts_if.sv -----
// request and response channel interfaces of the scheduler
`default_nettype none

interface pbts_req_if;
   import pbts_pkg::*;

   logic               valid;
   logic               ready;
   logic [ACT_W-1:0]   action;
   logic [PRIO_W-1:0]  prio;
   logic [TASK_W-1:0]  task_id;
   logic [TSTAT_W-1:0] task_status;
   logic               preemptable;
   logic               resource_held;
   logic [CTX_W-1:0]   call_context;
   logic               isr_level;
   logic               dispatch_locked;
   logic               os_running;

   modport source (
      output valid, action, prio, task_id, task_status, preemptable,
             resource_held, call_context, isr_level, dispatch_locked, os_running,
      input  ready
   );

   modport sink (
      input  valid, action, prio, task_id, task_status, preemptable,
             resource_held, call_context, isr_level, dispatch_locked, os_running,
      output ready
   );
endinterface

interface pbts_rsp_if;
   import pbts_pkg::*;

   logic              valid;
   logic              ready;
   logic [STAT_W-1:0] status;
   logic [TASK_W-1:0] high_task;
   logic              dispatch_now;
   logic              defer_dispatch;
   logic              preempted;
   logic              post_hook;

   modport source (
      output valid, status, high_task, dispatch_now, defer_dispatch, preempted,
             post_hook,
      input  ready
   );

   modport sink (
      input  valid, status, high_task, dispatch_now, defer_dispatch, preempted,
             post_hook,
      output ready
   );
endinterface

`default_nettype wire

// ----- rtl/pbts_ram.sv -----
// generic single write port ram with registered read
`default_nettype none

module pbts_ram #(
   parameter int WIDTH = pbts_pkg::TASK_W,
   parameter int DEPTH = pbts_pkg::PRIO_LEVELS_DEF
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire  [$clog2(DEPTH)-1:0] wr_addr,
   input  wire  [WIDTH-1:0]         wr_data,
   input  wire  [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

`default_nettype wire

// ----- rtl/priority_bitmap_task_scheduler.sv -----
// Priority bitmap task scheduler, top level.
//
// req_ch carries set, clear and schedule actions; rsp_ch returns exactly one
// result per accepted request, in request order. Set and clear only update
// the ready bitmap and the task table and return an all-zero result; a
// schedule returns the status, the highest ready task and the dispatch flags.
// The ready bitmap sits in flip-flops, the priority-to-task table in a RAM
// with a registered read.
// A request accepted on req_ch is held in the lookup stage, and its result is
// registered in the output register before it is offered on rsp_ch. A new
// request is taken only once the lookup stage is empty; the lookup stage holds
// a request while its table read result is used and any preempt write-back is
// done, and req_ch.ready stays low while it is held.
// The output register frees the lookup stage, so one request may be taken
// while a result waits on rsp_ch; with the receiver stalled one result waits
// and one more request sits in the lookup stage, then req_ch.ready stays low.
// Reset (synchronous, active high) clears the bitmap and empties both stages;
// table entries keep no reset value and are read only after being written.
`default_nettype none
`include "assert_macros.svh"

module priority_bitmap_task_scheduler #(
   parameter int PRIO_LEVELS = pbts_pkg::PRIO_LEVELS_DEF
) (
   input wire         clock,
   input wire         reset,
   pbts_req_if.sink   req_ch,
   pbts_rsp_if.source rsp_ch
);
   import pbts_pkg::*;

   localparam int IDX_W = $clog2(PRIO_LEVELS);
   localparam logic [PRIO_W:0] PRIO_LIM = (PRIO_W+1)'(PRIO_LEVELS);

   req_item_type            req_item;
   logic                    req_xfer;
   logic                    req_in_range;
   logic [IDX_W-1:0]        enc_hp;
   logic                    enc_found;

   logic                    s1_valid_ff, s1_valid_in;
   req_item_type            s1_item_ff;
   logic [IDX_W-1:0]        s1_hp_ff;
   logic                    s1_found_ff;
   logic                    s1_adv;
   logic                    s1_in_range;
   logic                    s1_pre_wr;
   logic [IDX_W-1:0]        s1_idx;

   logic [PRIO_LEVELS-1:0]  ready_bits_ff, ready_bits_in;

   logic                    ram_wr_en;
   logic [IDX_W-1:0]        ram_wr_addr;
   logic [TASK_W-1:0]       ram_wr_data;
   logic [IDX_W-1:0]        ram_rd_addr;
   logic [TASK_W-1:0]       ram_rd_data;

   rsp_item_type            res;
   logic [TASK_W-1:0]       high;
   logic                    cur_busy;
   logic                    high_busy;
   logic                    res_err;
   logic                    lvl_err;

   logic                    out_valid_ff, out_valid_in;
   rsp_item_type            out_item_ff;

   // request payload
   always_comb begin
      req_item.action          = req_ch.action;
      req_item.prio            = req_ch.prio;
      req_item.task_id         = req_ch.task_id;
      req_item.task_status     = req_ch.task_status;
      req_item.preemptable     = req_ch.preemptable;
      req_item.resource_held   = req_ch.resource_held;
      req_item.call_context    = req_ch.call_context;
      req_item.isr_level       = req_ch.isr_level;
      req_item.dispatch_locked = req_ch.dispatch_locked;
      req_item.os_running      = req_ch.os_running;
   end

   // handshakes
   assign req_ch.ready = !s1_valid_ff;
   assign req_xfer     = req_ch.valid && !s1_valid_ff;
   assign s1_adv       = s1_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_in_range = {1'b0, req_item.prio} < PRIO_LIM;

   // highest set bit of the ready bitmap
   always_comb begin
      enc_hp = '0;
      for (int i = 0; i < PRIO_LEVELS; i++) begin
         if (ready_bits_ff[i]) begin
            enc_hp = IDX_W'(i);
         end
      end
   end
   assign enc_found = |ready_bits_ff;

   // lookup stage
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_xfer) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_item_ff  <= req_item;
         s1_hp_ff    <= enc_hp;
         s1_found_ff <= enc_found;
      end
   end

   assign s1_idx      = s1_item_ff.prio[IDX_W-1:0];
   assign s1_in_range = {1'b0, s1_item_ff.prio} < PRIO_LIM;

   // task table: read the found priority, hold the address while stalled
   assign ram_rd_addr = s1_valid_ff ? s1_hp_ff : enc_hp;
   assign ram_wr_en   = (req_xfer && req_item.action == ACT_SET && req_in_range)
                        || (s1_adv && s1_pre_wr);
   assign ram_wr_addr = s1_valid_ff ? s1_idx : req_item.prio[IDX_W-1:0];
   assign ram_wr_data = s1_valid_ff ? s1_item_ff.task_id : req_item.task_id;

   pbts_ram #(
      .WIDTH (TASK_W),
      .DEPTH (PRIO_LEVELS)
   ) u_task_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // schedule decision
   always_comb begin
      res       = '0;
      res.status = ST_OK;
      high      = s1_found_ff ? ram_rd_data : IDLE_TASK_ID;
      cur_busy  = s1_item_ff.task_id < IDLE_TASK_ID;
      high_busy = high < IDLE_TASK_ID;
      res_err   = cur_busy && s1_item_ff.resource_held
                  && s1_item_ff.call_context != CTX_CAT2;
      lvl_err   = s1_item_ff.call_context != CTX_TASK
                  && s1_item_ff.call_context != CTX_CAT2;
      if (s1_item_ff.action == ACT_SCHED) begin
         if (res_err) begin
            res.status = ST_RES_ERR;
         end else if (lvl_err) begin
            res.status = ST_CALL_ERR;
         end else begin
            res.high_task = high;
            if (cur_busy && high_busy) begin
               if (s1_item_ff.task_status == TS_RUNNING
                   && PRIO_W'(s1_hp_ff) > s1_item_ff.prio) begin
                  if (s1_item_ff.preemptable) begin
                     res.post_hook = 1'b1;
                     res.preempted = 1'b1;
                     if (!s1_item_ff.isr_level && !s1_item_ff.dispatch_locked) begin
                        res.dispatch_now = 1'b1;
                     end else if (!s1_item_ff.dispatch_locked) begin
                        res.defer_dispatch = 1'b1;
                     end
                  end
               end else if (s1_item_ff.task_status == TS_SUSPENDED
                            || s1_item_ff.task_status == TS_WAITING) begin
                  res.post_hook    = 1'b1;
                  res.dispatch_now = 1'b1;
               end
            end else if (s1_item_ff.task_id == IDLE_TASK_ID && high_busy) begin
               if (s1_item_ff.isr_level && s1_item_ff.os_running) begin
                  res.defer_dispatch = 1'b1;
               end
            end else if (cur_busy && high == IDLE_TASK_ID) begin
               if (s1_item_ff.task_status != TS_RUNNING) begin
                  res.post_hook = 1'b1;
                  if (!s1_item_ff.isr_level) begin
                     res.dispatch_now = 1'b1;
                  end else begin
                     res.defer_dispatch = 1'b1;
                  end
               end
            end
         end
      end
   end

   assign s1_pre_wr = res.preempted && s1_in_range;

   // ready bitmap update
   always_comb begin
      ready_bits_in = ready_bits_ff;
      if (req_xfer && req_in_range) begin
         if (req_item.action == ACT_SET) begin
            ready_bits_in[req_item.prio[IDX_W-1:0]] = 1'b1;
         end else if (req_item.action == ACT_CLEAR) begin
            ready_bits_in[req_item.prio[IDX_W-1:0]] = 1'b0;
         end
      end
      if (s1_adv && s1_pre_wr) begin
         ready_bits_in[s1_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_bits_ff <= '0;
      end else begin
         ready_bits_ff <= ready_bits_in;
      end
   end

   // output register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (s1_adv) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         out_item_ff <= res;
      end
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.status         = out_item_ff.status;
   assign rsp_ch.high_task      = out_item_ff.high_task;
   assign rsp_ch.dispatch_now   = out_item_ff.dispatch_now;
   assign rsp_ch.defer_dispatch = out_item_ff.defer_dispatch;
   assign rsp_ch.preempted      = out_item_ff.preempted;
   assign rsp_ch.post_hook      = out_item_ff.post_hook;

   // checks
   `ASSERT_NEXT(a_adv_fills_out, clock, reset, s1_adv, out_valid_ff,
                "lookup stage advanced but no result registered")
   `ASSERT_IMPLY(a_err_fields_zero, clock, reset,
                 out_valid_ff && out_item_ff.status != ST_OK,
                 out_item_ff.high_task == '0 && !out_item_ff.dispatch_now
                 && !out_item_ff.defer_dispatch && !out_item_ff.preempted,
                 "error result carries schedule fields")
   `ASSERT_NEVER(a_now_and_defer, clock, reset,
                 out_valid_ff && out_item_ff.dispatch_now && out_item_ff.defer_dispatch,
                 "dispatch both immediate and deferred")
   `ASSERT_IMPLY(a_pre_hook, clock, reset, out_valid_ff && out_item_ff.preempted,
                 out_item_ff.post_hook, "preemption without post-task hook")
   `ASSERT_NEXT(a_pre_sets_bit, clock, reset, s1_adv && s1_pre_wr,
                ready_bits_ff[$past(s1_idx)], "preempted task not marked ready")
endmodule

`default_nettype wire

// ----- tb/pbts_sched_checker.sv -----
// scoreboard that predicts every scheduler response and compares it field by field
`default_nettype none

module pbts_sched_checker #(
   parameter int PRIO_LEVELS = pbts_pkg::PRIO_LEVELS_DEF
) (
   input  wire        clock,
   input  wire        reset,
   pbts_req_if        req_mon,
   pbts_rsp_if        rsp_mon,
   output int         fail_count,
   output int         pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import pbts_pkg::*;

   // shadow copy of the ready bitmap and the priority-to-task table
   logic [PRIO_LEVELS-1:0] ready_map;
   logic [TASK_W-1:0]      task_map [PRIO_LEVELS];

   // responses still owed by the block, oldest first
   rsp_item_type outcome_q[$];

   task automatic report_mismatch(string msg);
      $display("mismatch at %0t ns: %s", $time, msg);
      fail_count++;
   endtask

   // mark a level ready and remember its task; out-of-range levels are dropped
   function automatic void mark_level(logic [PRIO_W-1:0] lvl, logic [TASK_W-1:0] tid);
      if (lvl < PRIO_LEVELS) begin
         ready_map[lvl] = 1'b1;
         task_map[lvl]  = tid;
      end
   endfunction

   // apply one request to the shadow state and work out its response
   function automatic rsp_item_type compute_outcome(req_item_type rq);
      rsp_item_type r;
      int           top_lvl;
      bit           found;
      r       = '0;
      top_lvl = 0;
      found   = 1'b0;
      case (rq.action)
         ACT_SET: begin
            mark_level(rq.prio, rq.task_id);
         end
         ACT_CLEAR: begin
            if (rq.prio < PRIO_LEVELS)
               ready_map[rq.prio] = 1'b0;
         end
         ACT_SCHED: begin
            if (rq.task_id < IDLE_TASK_ID && rq.resource_held && rq.call_context != CTX_CAT2) begin
               r.status = ST_RES_ERR;
            end else if (rq.call_context != CTX_TASK && rq.call_context != CTX_CAT2) begin
               r.status = ST_CALL_ERR;
            end else begin
               // highest ready level wins
               for (int i = PRIO_LEVELS - 1; i >= 0; i--) begin
                  if (!found && ready_map[i]) begin
                     found   = 1'b1;
                     top_lvl = i;
                  end
               end
               r.high_task = found ? task_map[top_lvl] : IDLE_TASK_ID;
               if (rq.task_id < IDLE_TASK_ID && r.high_task < IDLE_TASK_ID) begin
                  if (rq.task_status == TS_RUNNING && top_lvl > int'(rq.prio)) begin
                     // preemption puts the current task back as ready
                     if (rq.preemptable) begin
                        r.post_hook = 1'b1;
                        r.preempted = 1'b1;
                        mark_level(rq.prio, rq.task_id);
                        if (!rq.isr_level && !rq.dispatch_locked)
                           r.dispatch_now = 1'b1;
                        else if (!rq.dispatch_locked)
                           r.defer_dispatch = 1'b1;
                     end
                  end else if (rq.task_status == TS_SUSPENDED || rq.task_status == TS_WAITING) begin
                     r.post_hook    = 1'b1;
                     r.dispatch_now = 1'b1;
                  end
               end else if (rq.task_id == IDLE_TASK_ID && r.high_task < IDLE_TASK_ID) begin
                  if (rq.isr_level && rq.os_running)
                     r.defer_dispatch = 1'b1;
               end else if (rq.task_id < IDLE_TASK_ID && r.high_task == IDLE_TASK_ID) begin
                  if (rq.task_status != TS_RUNNING) begin
                     r.post_hook = 1'b1;
                     if (!rq.isr_level)
                        r.dispatch_now = 1'b1;
                     else
                        r.defer_dispatch = 1'b1;
                  end
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // watch both channels; the response is checked before the new request is queued
   always @(posedge clock) begin
      req_item_type rq;
      rsp_item_type got;
      rsp_item_type want;
      if (reset) begin
         ready_map  = '0;
         outcome_q.delete();
         fail_count = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = {rsp_mon.status, rsp_mon.high_task, rsp_mon.dispatch_now,
                   rsp_mon.defer_dispatch, rsp_mon.preempted, rsp_mon.post_hook};
            if (outcome_q.size() == 0) begin
               report_mismatch($sformatf("response %p with no request pending", got));
            end else begin
               want = outcome_q.pop_front();
               if (got.status !== want.status)
                  report_mismatch($sformatf("status got %0d expected %0d",
                                            got.status, want.status));
               if (got.high_task !== want.high_task)
                  report_mismatch($sformatf("high_task got %0d expected %0d",
                                            got.high_task, want.high_task));
               if (got.dispatch_now !== want.dispatch_now)
                  report_mismatch($sformatf("dispatch_now got %b expected %b",
                                            got.dispatch_now, want.dispatch_now));
               if (got.defer_dispatch !== want.defer_dispatch)
                  report_mismatch($sformatf("defer_dispatch got %b expected %b",
                                            got.defer_dispatch, want.defer_dispatch));
               if (got.preempted !== want.preempted)
                  report_mismatch($sformatf("preempted got %b expected %b",
                                            got.preempted, want.preempted));
               if (got.post_hook !== want.post_hook)
                  report_mismatch($sformatf("post_hook got %b expected %b",
                                            got.post_hook, want.post_hook));
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            rq = {req_mon.action, req_mon.prio, req_mon.task_id, req_mon.task_status,
                  req_mon.preemptable, req_mon.resource_held, req_mon.call_context,
                  req_mon.isr_level, req_mon.dispatch_locked, req_mon.os_running};
            outcome_q.push_back(compute_outcome(rq));
         end
      end
      pending = outcome_q.size();
   end

endmodule

`default_nettype wire

// ----- tb/tb_priority_bitmap_task_scheduler.sv -----
// top of the scheduler testbench: clock, reset, request and response traffic, verdict
`default_nettype none

module tb_priority_bitmap_task_scheduler;
   timeunit 1ns;
   timeprecision 1ps;
   import pbts_pkg::*;

   // codes the package leaves unnamed
   localparam logic [ACT_W-1:0]   ACT_NOP  = 2'd3;
   localparam logic [TSTAT_W-1:0] TS_READY = 2'd1;
   localparam logic [CTX_W-1:0]   CTX_CAT1 = 2'd1;
   localparam logic [CTX_W-1:0]   CTX_BAD  = 2'd3;

   localparam int RANDOM_REQS = 1000;

   logic clock;
   logic reset;
   logic req_took;
   logic rsp_took;
   bit   steady_flow;
   int   fail_count;
   int   pending;

   pbts_req_if req_ch ();
   pbts_rsp_if rsp_ch ();

   priority_bitmap_task_scheduler i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   pbts_sched_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_ch),
      .rsp_mon    (rsp_ch),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // 4 ns clock
   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // note each transfer at the edge so the drivers can see it at the next falling edge
   always @(posedge clock) begin
      req_took <= req_ch.valid && req_ch.ready;
      rsp_took <= rsp_ch.valid && rsp_ch.ready;
   end

   function automatic int idle_cycles();
      return steady_flow ? 0 : $urandom_range(0, 5);
   endfunction

   function automatic req_item_type mk(logic [ACT_W-1:0] act, int prio, int tid,
                                       logic [TSTAT_W-1:0] tstat, bit fullp, bit res,
                                       logic [CTX_W-1:0] ctx, bit isr, bit locked,
                                       bit os_up);
      req_item_type rq;
      rq = {act, PRIO_W'(prio), TASK_W'(tid), tstat, fullp, res, ctx, isr, locked, os_up};
      return rq;
   endfunction

   // mostly well-formed traffic with some out-of-range and erroneous requests
   function automatic req_item_type random_request();
      req_item_type rq;
      int           pick;
      rq   = req_item_type'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 40)
         rq.action = ACT_SET;
      else if (pick < 60)
         rq.action = ACT_CLEAR;
      else if (pick < 95)
         rq.action = ACT_SCHED;
      else
         rq.action = ACT_NOP;
      if ($urandom_range(0, 9) != 0)
         rq.prio = PRIO_W'($urandom_range(0, 31));
      if ($urandom_range(0, 9) != 0)
         rq.task_id = TASK_W'($urandom_range(0, 16));
      if (rq.action == ACT_SCHED && $urandom_range(0, 5) == 0)
         rq.task_id = IDLE_TASK_ID;
      if ($urandom_range(0, 4) != 0)
         rq.resource_held = 1'b0;
      if ($urandom_range(0, 7) != 0)
         rq.call_context = $urandom_range(0, 1) ? CTX_CAT2 : CTX_TASK;
      return rq;
   endfunction

   // one request transfer, starting and ending at a falling edge
   task automatic send_request(req_item_type rq);
      int gap;
      gap = idle_cycles();
      repeat (gap) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      {req_ch.action, req_ch.prio, req_ch.task_id, req_ch.task_status, req_ch.preemptable,
       req_ch.resource_held, req_ch.call_context, req_ch.isr_level, req_ch.dispatch_locked,
       req_ch.os_running} <= rq;
      do @(negedge clock); while (!req_took);
   endtask

   // response side: random stall before each transfer
   initial begin
      int stall;
      rsp_ch.ready = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         stall = idle_cycles();
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(negedge clock); while (!rsp_took);
      end
   end

   // stimulus and verdict
   initial begin
      req_ch.valid           = 1'b0;
      req_ch.action          = ACT_SET;
      req_ch.prio            = '0;
      req_ch.task_id         = '0;
      req_ch.task_status     = TS_RUNNING;
      req_ch.preemptable     = 1'b0;
      req_ch.resource_held   = 1'b0;
      req_ch.call_context    = CTX_TASK;
      req_ch.isr_level       = 1'b0;
      req_ch.dispatch_locked = 1'b0;
      req_ch.os_running      = 1'b0;
      steady_flow            = 1'b0;
      reset                  = 1'b1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // lowest and highest levels, then ignored out-of-range set and clear, unused action
      send_request(mk(ACT_SET,   0,  0, TS_RUNNING,   0, 0, CTX_TASK, 0, 0, 0));
      send_request(mk(ACT_SET,   31, 15, TS_RUNNING,  0, 0, CTX_TASK, 0, 0, 0));
      send_request(mk(ACT_SET,   63, 31, TS_SUSPENDED, 1, 1, CTX_BAD, 1, 1, 1));
      send_request(mk(ACT_CLEAR, 40, 0, TS_RUNNING,   0, 0, CTX_TASK, 0, 0, 0));
      send_request(mk(ACT_NOP,   63, 31, TS_SUSPENDED, 1, 1, CTX_BAD, 1, 1, 1));
      // resource error and both call level errors
      send_request(mk(ACT_SCHED, 2,  3, TS_RUNNING,   0, 1, CTX_TASK, 0, 0, 1));
      send_request(mk(ACT_SCHED, 2, 16, TS_RUNNING,   0, 0, CTX_CAT1, 0, 0, 1));
      send_request(mk(ACT_SCHED, 2, 20, TS_RUNNING,   0, 1, CTX_BAD,  0, 0, 1));
      // current task id above idle
      send_request(mk(ACT_SCHED, 2, 20, TS_RUNNING,   1, 0, CTX_TASK, 0, 0, 1));
      // preemption: dispatch now, deferred, locked
      send_request(mk(ACT_SCHED, 5,  2, TS_RUNNING,   1, 0, CTX_TASK, 0, 0, 1));
      send_request(mk(ACT_SCHED, 3,  4, TS_RUNNING,   1, 0, CTX_CAT2, 1, 0, 1));
      send_request(mk(ACT_SCHED, 1,  6, TS_RUNNING,   1, 0, CTX_TASK, 1, 1, 1));
      // no preemption: not preemptable, or already at the top level
      send_request(mk(ACT_SCHED, 2,  7, TS_RUNNING,   0, 0, CTX_TASK, 0, 0, 1));
      send_request(mk(ACT_SCHED, 31, 8, TS_RUNNING,   1, 0, CTX_TASK, 0, 0, 1));
      // waiting or suspended task dispatches now even at interrupt level
      send_request(mk(ACT_SCHED, 4,  9, TS_WAITING,   0, 0, CTX_TASK, 1, 0, 1));
      send_request(mk(ACT_SCHED, 4,  9, TS_SUSPENDED, 0, 1, CTX_CAT2, 1, 1, 1));
      // idle current task
      send_request(mk(ACT_SCHED, 0, 16, TS_RUNNING,   0, 0, CTX_CAT2, 1, 0, 1));
      send_request(mk(ACT_SCHED, 0, 16, TS_RUNNING,   0, 0, CTX_CAT2, 1, 0, 0));
      // empty the bitmap, then schedule with only the idle task left
      send_request(mk(ACT_CLEAR, 31, 0, TS_RUNNING,   0, 0, CTX_TASK, 0, 0, 0));
      send_request(mk(ACT_CLEAR, 5,  0, TS_RUNNING,   0, 0, CTX_TASK, 0, 0, 0));
      send_request(mk(ACT_CLEAR, 3,  0, TS_RUNNING,   0, 0, CTX_TASK, 0, 0, 0));
      send_request(mk(ACT_CLEAR, 1,  0, TS_RUNNING,   0, 0, CTX_TASK, 0, 0, 0));
      send_request(mk(ACT_CLEAR, 0,  0, TS_RUNNING,   0, 0, CTX_TASK, 0, 0, 0));
      send_request(mk(ACT_SCHED, 6, 10, TS_READY,     0, 0, CTX_TASK, 0, 0, 1));
      send_request(mk(ACT_SCHED, 6, 10, TS_WAITING,   0, 0, CTX_TASK, 1, 0, 1));
      // table entry holding a task id above idle
      send_request(mk(ACT_SET,   10, 31, TS_RUNNING,  0, 0, CTX_TASK, 0, 0, 0));
      send_request(mk(ACT_SCHED, 2,  2, TS_RUNNING,   1, 0, CTX_TASK, 0, 0, 1));
      send_request(mk(ACT_CLEAR, 10, 0, TS_RUNNING,   0, 0, CTX_TASK, 0, 0, 0));

      // random traffic, with occasional stretches of back-to-back transfers
      for (int n = 0; n < RANDOM_REQS; n++) begin
         if (n % 64 == 0)
            steady_flow = ($urandom_range(0, 3) == 0);
         send_request(random_request());
      end
      req_ch.valid <= 1'b0;
      steady_flow = 1'b0;

      // drain, then keep watching for stray responses before the verdict
      while (pending != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (fail_count == 0)
         $display("PASS priority_bitmap_task_scheduler");
      else
         $display("FAIL priority_bitmap_task_scheduler");
      $finish;
   end

   // watchdog
   initial begin
      #2ms;
      $display("FAIL priority_bitmap_task_scheduler");
      $finish;
   end

endmodule

`default_nettype wire

// ----- files.f -----
+incdir+rtl
rtl/pbts_pkg.sv
rtl/pbts_if.sv
rtl/pbts_ram.sv
rtl/priority_bitmap_task_scheduler.sv
tb/pbts_sched_checker.sv
tb/tb_priority_bitmap_task_scheduler.sv
